// ===== rtl/ipv4hc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4hc_pkg
// Shared types and constants for the IPv4 header checker.
// ----------------------------------------------------------------------------
package ipv4hc_pkg;

  localparam int unsigned COUNT_LIMIT_DEF = 2047;
  localparam int unsigned HDR_BYTES       = 20;
  localparam int unsigned CFG_IDX_W       = 8;
  localparam int unsigned CFG_DATA_W      = 11;
  localparam int unsigned PAY_W           = 11;

  localparam logic [CFG_IDX_W-1:0] REG_EXP_PROTO   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = CFG_IDX_W'(1);

  localparam logic [7:0]       EXP_PROTO_RST   = 8'd1;
  localparam logic [PAY_W-1:0] MAX_PAYLOAD_RST = PAY_W'(1480);
  localparam logic [PAY_W-1:0] PAY_SAT         = '1;
  localparam logic [15:0]      SUM_GOOD        = 16'hFFFF;
  localparam logic [3:0]       HDR_VERSION     = 4'd4;
  localparam logic [3:0]       IP_IHL          = 4'd5;

  // error flag positions
  localparam int unsigned ERR_VERSION  = 0;
  localparam int unsigned ERR_IHL      = 1;
  localparam int unsigned ERR_SHORT    = 2;
  localparam int unsigned ERR_PROTO    = 3;
  localparam int unsigned ERR_CHECKSUM = 4;
  localparam int unsigned ERR_TOO_LONG = 5;
  localparam int unsigned ERR_TTL      = 6;

  // header bytes, index 0 is the first byte on the wire
  typedef logic [HDR_BYTES-1:0][7:0] hdr_t;

  // verdict word, last field in the lowest bits
  typedef struct packed {
    logic [4:0]       pad;
    logic [31:0]      dst_addr;
    logic [31:0]      src_addr;
    logic [7:0]       protocol_number;
    logic [7:0]       ttl;
    logic [12:0]      fragment_offset;
    logic [2:0]       fragment_flags;
    logic [15:0]      identification;
    logic [15:0]      tot_len;
    logic [7:0]       service_type;
    logic [PAY_W-1:0] payload_length;
    logic [6:0]       error_flags;
    logic             accepted;
  } result_t;

  typedef struct packed {
    logic [7:0]       exp_proto;
    logic [PAY_W-1:0] max_payload;
  } cfg_t;

endpackage

// ===== rtl/ipv4_header_checker.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_checker
// Parses IPv4 packet bytes, checks the header and emits one verdict word.
// ----------------------------------------------------------------------------
// channel | dir | tdata / data              | side signals
// in_     | in  | [7:0] data_byte           | tuser first_byte, tlast last_byte
// out_    | out | [159:0] verdict word      | -
// cfg_    | in  | [10:0] register value     | cfg_index selects the register
//
// One input word per cycle unless a stalled result holds back a last byte; the last
// byte passes the input register, then its verdict is held in the result register.
// Reset (rst_n low, synchronous) restores register defaults and restarts parsing.
// A stalled result only holds back the next last byte, and with it the input; bytes before it keep flowing.
// ----------------------------------------------------------------------------
module ipv4_header_checker import ipv4hc_pkg::*; #(
  parameter int unsigned COUNT_LIMIT = COUNT_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] first_byte
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [159:0]          out_tdata,  // accepted, error_flags, payload_length,
                                            // service_type, tot_len, identification,
                                            // fragment_flags, fragment_offset, ttl,
                                            // protocol_number, src_addr,
                                            // dst_addr, zero pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CW = $clog2(COUNT_LIMIT + 1);

  cfg_t          cfg_r;

  logic          s0_valid_r;
  logic [7:0]    s0_byte_r;
  logic          s0_first_r;
  logic          s0_last_r;
  logic          s0_go;
  logic          proc;

  logic [CW-1:0] cnt_r, cnt_eff, cnt_nxt;
  logic [15:0]   sum_r, sum_eff, sum_nxt;
  logic [16:0]   sum_raw;
  logic [7:0]    pend_r, pend_nxt;
  hdr_t          hdr_r, hdr_nxt;
  logic          rstp_r;
  logic          restart;

  logic          out_valid_r;
  result_t       result_r, result_nxt;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.exp_proto   <= EXP_PROTO_RST;
      cfg_r.max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_EXP_PROTO:   cfg_r.exp_proto   <= cfg_data[7:0];
        REG_MAX_PAYLOAD: cfg_r.max_payload <= cfg_data[PAY_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign s0_go     = !s0_last_r || !out_valid_r || out_tready;
  assign proc      = s0_valid_r && s0_go;
  assign in_tready = !s0_valid_r || s0_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s0_valid_r <= 1'b1;
    end else if (s0_go) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s0_byte_r  <= in_tdata;
      s0_first_r <= in_tuser;
      s0_last_r  <= in_tlast;
    end
  end

  // parse state update
  assign restart = s0_first_r || rstp_r;

  always_comb begin
    cnt_eff  = restart ? '0 : cnt_r;
    sum_eff  = restart ? '0 : sum_r;
    hdr_nxt  = restart ? '0 : hdr_r;
    pend_nxt = restart ? '0 : pend_r;
    sum_nxt  = sum_eff;
    sum_raw  = {1'b0, sum_eff} + {1'b0, pend_nxt, s0_byte_r};
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (cnt_eff == CW'(i)) hdr_nxt[i] = s0_byte_r;
    end
    if (cnt_eff < CW'(HDR_BYTES)) begin
      if (!cnt_eff[0]) begin
        pend_nxt = s0_byte_r;
      end else begin
        sum_nxt = sum_raw[15:0] + {15'd0, sum_raw[16]};
      end
    end
    cnt_nxt = (cnt_eff < CW'(COUNT_LIMIT)) ? cnt_eff + CW'(1) : cnt_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rstp_r <= 1'b1;
    end else if (proc) begin
      rstp_r <= s0_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      pend_r <= pend_nxt;
      hdr_r  <= hdr_nxt;
    end
  end

  ipv4hc_verdict #(
    .CW (CW)
  ) u_verdict (
    .hdr      (hdr_nxt),
    .byte_cnt (cnt_nxt),
    .sum      (sum_nxt),
    .cfg      (cfg_r),
    .result   (result_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && s0_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s0_last_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = result_r;

`ifndef NO_ASSERTIONS
  a_accept_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (result_r.accepted == (result_r.error_flags == 7'd0)))
    else $error("accepted disagrees with error flags");

  a_sanity_masks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (result_r.error_flags[2:0] != 3'd0))
      |-> (result_r.error_flags[6:3] == 4'd0))
    else $error("late checks reported alongside a sanity error");

  a_restart_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && s0_last_r) |=> (rstp_r && out_valid_r))
    else $error("verdict not followed by a parse restart");
`endif

endmodule

// ===== rtl/ipv4hc_verdict.sv =====
// ----------------------------------------------------------------------------
// ipv4hc_verdict
// Header field extraction and pass/fail checks for one finished packet.
// ----------------------------------------------------------------------------
module ipv4hc_verdict import ipv4hc_pkg::*; #(
  parameter int unsigned CW = 11
) (
  input  hdr_t          hdr,
  input  logic [CW-1:0] byte_cnt,
  input  logic [15:0]   sum,
  input  cfg_t          cfg,
  output result_t       result
);

  localparam int unsigned PW = (CW > PAY_W) ? CW : PAY_W;

  logic [PW-1:0] cnt_w;
  logic [PW-1:0] payload_w;
  logic [2:0]    sanity;
  logic [3:0]    checks;
  logic [6:0]    flags;

  always_comb begin
    cnt_w     = PW'(byte_cnt);
    payload_w = (cnt_w >= PW'(HDR_BYTES)) ? cnt_w - PW'(HDR_BYTES) : '0;

    sanity[ERR_VERSION] = hdr[0][7:4] != HDR_VERSION;
    sanity[ERR_IHL]     = hdr[0][3:0] != IP_IHL;
    sanity[ERR_SHORT]   = cnt_w < PW'(HDR_BYTES);

    checks[ERR_PROTO-3]    = hdr[9] != cfg.exp_proto;
    checks[ERR_CHECKSUM-3] = sum != SUM_GOOD;
    checks[ERR_TOO_LONG-3] = payload_w > PW'(cfg.max_payload);
    checks[ERR_TTL-3]      = hdr[8] == 8'd0;

    flags = (|sanity) ? {4'd0, sanity} : {checks, 3'd0};

    result.pad             = '0;
    result.accepted        = flags == 7'd0;
    result.error_flags     = flags;
    result.payload_length  = (payload_w > PW'(PAY_SAT)) ? PAY_SAT : payload_w[PAY_W-1:0];
    result.service_type    = hdr[1];
    result.tot_len         = {hdr[2], hdr[3]};
    result.identification  = {hdr[4], hdr[5]};
    result.fragment_flags  = hdr[6][7:5];
    result.fragment_offset = {hdr[6][4:0], hdr[7]};
    result.ttl             = hdr[8];
    result.protocol_number = hdr[9];
    result.src_addr        = {hdr[12], hdr[13], hdr[14], hdr[15]};
    result.dst_addr        = {hdr[16], hdr[17], hdr[18], hdr[19]};
  end

endmodule

// ===== bench/ipv4hc_verdict_check.sv =====
// ----------------------------------------------------------------------------
// ipv4hc_verdict_check
// Watches the byte, verdict and register channels of the IPv4 header checker,
// mirrors its parse state and registers, predicts one verdict per last byte
// and compares every verdict word field by field against the oldest one.
// ----------------------------------------------------------------------------
module ipv4hc_verdict_check import ipv4hc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [159:0]          out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           fail_count,
  output int unsigned           pending_count
);

  result_t          verdict_q[$];
  int unsigned      errs = 0;

  logic [7:0]       exp_proto;
  logic [PAY_W-1:0] max_pay;

  int unsigned      cnt;
  logic [15:0]      csum;
  logic [7:0]       hi_byte;
  hdr_t             hdr;
  logic             restart_due;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task clear_parse();
    cnt         = 0;
    csum        = '0;
    hi_byte     = '0;
    hdr         = '0;
    restart_due = 1'b0;
  endtask

  task parse_byte(input logic [7:0] b, input logic f, input logic l);
    result_t     v;
    logic [16:0] s;
    logic [15:0] frag;
    int unsigned pay;
    if (f || restart_due) clear_parse();
    if (cnt < HDR_BYTES) begin
      hdr[cnt] = b;
      if (cnt % 2 == 0) begin
        hi_byte = b;
      end else begin
        s    = csum + {hi_byte, b};
        s    = s[15:0] + s[16];
        csum = s[15:0];
      end
    end
    if (cnt < COUNT_LIMIT_DEF) cnt++;
    if (l) begin
      v = '0;
      if (hdr[0][7:4] != HDR_VERSION) v.error_flags[ERR_VERSION] = 1'b1;
      if (hdr[0][3:0] != IP_IHL)      v.error_flags[ERR_IHL]     = 1'b1;
      if (cnt < HDR_BYTES)            v.error_flags[ERR_SHORT]   = 1'b1;
      pay = (cnt >= HDR_BYTES) ? cnt - HDR_BYTES : 0;
      // protocol, checksum, length and TTL only count once sanity holds
      if (v.error_flags == '0) begin
        if (hdr[9] != exp_proto) v.error_flags[ERR_PROTO]    = 1'b1;
        if (csum != SUM_GOOD)    v.error_flags[ERR_CHECKSUM] = 1'b1;
        if (pay > max_pay)       v.error_flags[ERR_TOO_LONG] = 1'b1;
        if (hdr[8] == 8'd0)      v.error_flags[ERR_TTL]      = 1'b1;
      end
      frag              = {hdr[6], hdr[7]};
      v.accepted        = (v.error_flags == '0);
      v.payload_length  = (pay > PAY_SAT) ? PAY_SAT : PAY_W'(pay);
      v.service_type    = hdr[1];
      v.tot_len         = {hdr[2], hdr[3]};
      v.identification  = {hdr[4], hdr[5]};
      v.fragment_flags  = frag[15:13];
      v.fragment_offset = frag[12:0];
      v.ttl             = hdr[8];
      v.protocol_number = hdr[9];
      v.src_addr        = {hdr[12], hdr[13], hdr[14], hdr[15]};
      v.dst_addr        = {hdr[16], hdr[17], hdr[18], hdr[19]};
      verdict_q.push_back(v);
      restart_due = 1'b1;
    end
  endtask

  task cmp_field(input string fname, input logic [31:0] e, input logic [31:0] a);
    if (a !== e) begin
      $display("%0t: %s expected %0h actual %0h", $time, fname, e, a);
      errs++;
    end
  endtask

  task check_verdict(input result_t got);
    result_t e;
    if (verdict_q.size() == 0) begin
      $display("%0t: verdict with none expected, actual %h", $time, got);
      errs++;
    end else begin
      e = verdict_q.pop_front();
      cmp_field("accepted",        e.accepted,        got.accepted);
      cmp_field("error_flags",     e.error_flags,     got.error_flags);
      cmp_field("payload_length",  e.payload_length,  got.payload_length);
      cmp_field("service_type",    e.service_type,    got.service_type);
      cmp_field("tot_len",         e.tot_len,         got.tot_len);
      cmp_field("identification",  e.identification,  got.identification);
      cmp_field("fragment_flags",  e.fragment_flags,  got.fragment_flags);
      cmp_field("fragment_offset", e.fragment_offset, got.fragment_offset);
      cmp_field("ttl",             e.ttl,             got.ttl);
      cmp_field("protocol_number", e.protocol_number, got.protocol_number);
      cmp_field("src_addr",        e.src_addr,        got.src_addr);
      cmp_field("dst_addr",        e.dst_addr,        got.dst_addr);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      exp_proto = EXP_PROTO_RST;
      max_pay   = MAX_PAYLOAD_RST;
      clear_parse();
      verdict_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_verdict(result_t'(out_tdata));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_EXP_PROTO)   exp_proto = cfg_data[7:0];
        if (cfg_index == REG_MAX_PAYLOAD) max_pay   = cfg_data[PAY_W-1:0];
      end
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tuser, in_tlast);
    end
    pending_count <= verdict_q.size();
    fail_count    <= errs;
  end

endmodule

// ===== bench/tb_ipv4_header_checker.sv =====
// ----------------------------------------------------------------------------
// tb_ipv4_header_checker
// Drives IPv4 packets into the header checker: a directed set of corner
// packets, then phases of random packets under different register settings,
// mostly well-formed headers with random content plus damaged, short, long,
// unmarked and restarted ones. Random gaps on the byte side and random
// stalls on the verdict side; the verdict checker reports the failures.
// ----------------------------------------------------------------------------
module tb_ipv4_header_checker;
  import ipv4hc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [159:0]          out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int unsigned fail_count;
  int unsigned pending_count;

  logic [7:0]  pkt_q[$];
  logic [7:0]  cur_proto  = EXP_PROTO_RST;
  bit          no_gaps    = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned hold_left  = 0;
  int unsigned pick;

  ipv4_header_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ipv4hc_verdict_check verdict_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // verdict side backpressure: mostly ready, short and occasional long stalls
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        out_tready <= 1'b1;
        hold_left  <= $urandom_range(0, 20);
      end else if (pick < 72) begin
        out_tready <= 1'b1;
        hold_left  <= $urandom_range(50, 200);
      end else if (pick < 95) begin
        out_tready <= 1'b0;
        hold_left  <= $urandom_range(0, 4);
      end else begin
        out_tready <= 1'b0;
        hold_left  <= $urandom_range(10, 60);
      end
    end
  end

  function automatic hdr_t make_header(input logic [7:0] proto, input logic [7:0] ttl,
                                       input int unsigned pay);
    hdr_t        h;
    logic [15:0] tl;
    for (int i = 0; i < HDR_BYTES; i++) h[i] = 8'($urandom);
    tl   = 16'(HDR_BYTES + pay);
    h[0] = {HDR_VERSION, IP_IHL};
    h[2] = tl[15:8];
    h[3] = tl[7:0];
    h[8] = ttl;
    h[9] = proto;
    return h;
  endfunction

  // one's complement checksum over the header so the full sum folds to all ones
  function automatic hdr_t seal(input hdr_t h);
    logic [16:0] s;
    logic [15:0] c;
    h[10] = '0;
    h[11] = '0;
    c     = '0;
    for (int i = 0; i < HDR_BYTES; i += 2) begin
      s = c + {h[i], h[i+1]};
      c = s[15:0] + s[16];
    end
    c     = ~c;
    h[10] = c[15:8];
    h[11] = c[7:0];
    return h;
  endfunction

  task automatic fill_packet(input hdr_t h, input int unsigned n);
    for (int i = 0; i < n; i++) pkt_q.push_back((i < HDR_BYTES) ? h[i] : 8'($urandom));
  endtask

  task automatic push_byte(input logic [7:0] b, input logic f, input logic l);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60)  gap = 0;
    else if (r < 90)        gap = $urandom_range(1, 3);
    else if (r < 98)        gap = $urandom_range(4, 10);
    else                    gap = $urandom_range(20, 40);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= f;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_packet(input bit mark_first, input int restart_at);
    int n;
    n       = pkt_q.size();
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++)
      push_byte(pkt_q[i], (i == 0 && mark_first) || i == restart_at, i == n - 1);
    bytes_sent += n;
    pkt_q.delete();
  endtask

  task automatic wait_idle(input int unsigned tail);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [7:0] proto, input logic [CFG_DATA_W-1:0] maxp);
    wait_idle(4);
    write_reg(REG_EXP_PROTO, {3'($urandom), proto});
    write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
    write_reg(REG_MAX_PAYLOAD, maxp);
    cfg_valid <= 1'b0;
    cur_proto = proto;
  endtask

  task automatic random_packet();
    hdr_t        h;
    int unsigned pay;
    int unsigned nbytes;
    int unsigned noise;
    int unsigned r;
    bit          mark;
    pay = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    h   = make_header(($urandom_range(0, 9) < 7) ? cur_proto : 8'($urandom),
                      ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)), pay);
    r = $urandom_range(0, 99);
    if (r < 6)       h[0][7:4] = 4'($urandom);
    else if (r < 12) h[0][3:0] = 4'($urandom);
    h = seal(h);
    if ($urandom_range(0, 9) == 0) h[10 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    nbytes = HDR_BYTES + pay;
    if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(1, HDR_BYTES - 1);
    noise = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 8) : 0;
    repeat (noise) pkt_q.push_back(8'($urandom));
    fill_packet(h, nbytes);
    if (noise != 0) begin
      mark = $urandom_range(0, 1);
      send_packet(mark, noise);
    end else begin
      mark = ($urandom_range(0, 7) != 0);
      send_packet(mark, -1);
    end
  endtask

  initial begin
    hdr_t        h;
    int unsigned phase_start;
    int unsigned pkts;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed packets, register defaults
    h = seal(make_header(EXP_PROTO_RST, 8'd64, 0));
    fill_packet(h, 20);
    send_packet(1, -1);
    h    = '1;
    h[0] = {HDR_VERSION, IP_IHL};
    h[2] = 8'h00;
    h[3] = 8'd26;
    h[9] = EXP_PROTO_RST;
    fill_packet(seal(h), 26);
    send_packet(1, -1);
    h    = '0;
    h[0] = {HDR_VERSION, IP_IHL};
    h[3] = 8'd20;
    h[8] = 8'd1;
    h[9] = EXP_PROTO_RST;
    fill_packet(seal(h), 20);
    send_packet(1, -1);
    pkt_q.push_back(8'h00);
    send_packet(1, -1);
    pkt_q.push_back(8'hFF);
    send_packet(1, -1);
    h = seal(make_header(EXP_PROTO_RST, 8'd64, 0));
    fill_packet(h, 19);
    send_packet(1, -1);
    h    = make_header(EXP_PROTO_RST, 8'd64, 0);
    h[0] = 8'h66;
    fill_packet(h, 10);
    send_packet(1, -1);
    // unmarked first byte right after a verdict
    h = seal(make_header(EXP_PROTO_RST, 8'd9, 4));
    fill_packet(h, 24);
    send_packet(0, -1);
    // stray bytes, then a restart mark
    repeat (5) pkt_q.push_back(8'($urandom));
    fill_packet(seal(make_header(EXP_PROTO_RST, 8'd200, 4)), 24);
    send_packet(1, 5);
    fill_packet(seal(make_header(EXP_PROTO_RST, 8'd0, 2)), 22);
    send_packet(1, -1);
    h     = seal(make_header(EXP_PROTO_RST, 8'd64, 0));
    h[11] = h[11] ^ 8'h01;
    fill_packet(h, 20);
    send_packet(1, -1);

    wait_idle(4);
    write_reg(REG_EXP_PROTO, 11'h7FF);
    write_reg(REG_MAX_PAYLOAD, 11'd0);
    write_reg(8'hFF, 11'h7FF);
    write_reg(8'd2, 11'd0);
    cfg_valid <= 1'b0;
    cur_proto = 8'hFF;

    fill_packet(seal(make_header(8'hFF, 8'd64, 1)), 21);
    send_packet(1, -1);
    h     = seal(make_header(8'd1, 8'd0, 3));
    h[10] = h[10] ^ 8'h80;
    fill_packet(h, 23);
    send_packet(1, -1);
    h[0] = 8'h35;
    fill_packet(h, 23);
    send_packet(1, -1);

    // random phases under several register settings
    for (int p = 0; p < 4; p++) begin
      unique case (p)
        0:       set_config(8'($urandom), CFG_DATA_W'($urandom_range(0, 16)));
        1:       set_config(8'd0, 11'd2027);
        2:       set_config(8'($urandom), MAX_PAYLOAD_RST);
        default: set_config(8'hFF, CFG_DATA_W'($urandom_range(0, 8)));
      endcase
      phase_start = bytes_sent;
      pkts        = 0;
      while (bytes_sent - phase_start < 180 || pkts < 6) begin
        random_packet();
        pkts++;
      end
    end

    wait_idle(16);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ipv4hc_pkg.sv
rtl/ipv4hc_verdict.sv
rtl/ipv4_header_checker.sv
bench/ipv4hc_verdict_check.sv
bench/tb_ipv4_header_checker.sv
